FILE: hw/rtl/jsu_pkg.sv
// Shared types, character codes and UTF-8 helpers for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_EOF     = 2'd1;
  localparam logic [1:0] ERR_ESCAPE  = 2'd2;
  localparam logic [1:0] ERR_CONTROL = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam int MAX_RES = 4;

  typedef enum logic [6:0] {
    PH_PLAIN    = 7'b0000001,
    PH_ESC      = 7'b0000010,
    PH_HEX1     = 7'b0000100,
    PH_HELD     = 7'b0001000,
    PH_HELD_ESC = 7'b0010000,
    PH_HEX2     = 7'b0100000,
    PH_IDLE     = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] hex_accum;
    logic [1:0]  digit_count;
    logic        bad_digit_seen;
    logic [9:0]  held_high;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] error_code;
  } res_t;

  typedef struct packed {
    logic [2:0]               n;
    res_t [MAX_RES-1:0]       r;
  } res_list_t;

  function automatic res_t data_res(input logic [7:0] b);
    res_t x;
    x.out_byte   = b;
    x.kind       = KIND_DATA;
    x.error_code = ERR_NONE;
    return x;
  endfunction

  function automatic res_list_t one_res(input res_t x);
    res_list_t l;
    l      = '0;
    l.n    = 3'd1;
    l.r[0] = x;
    return l;
  endfunction

  function automatic res_list_t fail_res(input logic [1:0] code);
    res_t x;
    x.out_byte   = 8'h00;
    x.kind       = KIND_ERROR;
    x.error_code = code;
    return one_res(x);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end else begin
      v = 5'd0;
    end
    return v;
  endfunction

  // UTF-8 encoding of a code point; surrogates in the BMP become '?'
  function automatic res_list_t encode(input logic [20:0] cp);
    res_list_t l;
    l = '0;
    if (cp < 21'h80) begin
      l.n    = 3'd1;
      l.r[0] = data_res(cp[7:0]);
    end else if (cp < 21'h800) begin
      l.n    = 3'd2;
      l.r[0] = data_res({3'b110, cp[10:6]});
      l.r[1] = data_res({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
        l.n    = 3'd1;
        l.r[0] = data_res(CH_QMARK);
      end else begin
        l.n    = 3'd3;
        l.r[0] = data_res({4'b1110, cp[15:12]});
        l.r[1] = data_res({2'b10, cp[11:6]});
        l.r[2] = data_res({2'b10, cp[5:0]});
      end
    end else begin
      l.n    = 3'd4;
      l.r[0] = data_res({5'b11110, cp[20:18]});
      l.r[1] = data_res({2'b10, cp[17:12]});
      l.r[2] = data_res({2'b10, cp[11:6]});
      l.r[3] = data_res({2'b10, cp[5:0]});
    end
    return l;
  endfunction

endpackage

FILE: hw/rtl/json_string_unescape_top.sv
// Top level of the JSON string unescaper: parser state, decode and result register.
`timescale 1ns / 1ps

// Takes the bytes of a JSON string body (after the opening quote), one per
// transfer on s_*, with a zero byte meaning end of text, and sends decoded UTF-8
// bytes, a done marker on the closing quote, or an error on m_*. An input byte
// that yields one result or none is taken every cycle while m_* does not stall;
// a byte that yields several results (escapes expanding to 2..4 UTF-8 bytes, or
// a dropped surrogate '?' followed by more) holds s_tready low until its last
// result is taken, as the result register drains one byte per cycle while
// m_tready is high. The first result appears in the cycle after its input
// transfer. m_tlast marks the final result of each input byte. After done or
// error the block drops bytes without results until a '"' starts a new body.
module json_string_unescape_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] error_code, [15:10] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  jsu_pkg::dec_state_t st;
  jsu_pkg::dec_state_t st_next;
  jsu_pkg::res_list_t  res;
  jsu_pkg::res_t       m_res;
  logic                can_load;
  logic                xfer;

  assign s_tready = can_load;
  assign xfer     = s_tvalid & s_tready;

  jsu_decode u_decode (
    .st      (st),
    .in_byte (s_tdata),
    .st_next (st_next),
    .res     (res)
  );

  jsu_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (xfer),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res),
    .m_last   (m_tlast)
  );

  // phase in the top bits, hex registers and held surrogate cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= {jsu_pkg::PH_PLAIN, 29'd0};
    end else if (xfer) begin
      st <= st_next;
    end
  end

  assign m_tdata = {6'd0, m_res.error_code, m_res.out_byte};
  assign m_tuser = m_res.kind;

endmodule

FILE: hw/rtl/jsu_decode.sv
// Per-byte decode: next parser state and the list of result bytes for one input byte.
`timescale 1ns / 1ps

module jsu_decode (
  input  jsu_pkg::dec_state_t st,
  input  logic [7:0]          in_byte,
  output jsu_pkg::dec_state_t st_next,
  output jsu_pkg::res_list_t  res
);

  typedef struct packed {
    jsu_pkg::res_list_t l;
    jsu_pkg::phase_t    ph;
  } step_t;

  function automatic step_t do_plain(input logic [7:0] c);
    step_t s;
    jsu_pkg::res_t done;
    done.out_byte   = 8'h00;
    done.kind       = jsu_pkg::KIND_DONE;
    done.error_code = jsu_pkg::ERR_NONE;
    s.l  = '0;
    s.ph = jsu_pkg::PH_PLAIN;
    if (c == jsu_pkg::CH_NUL) begin
      s.l  = jsu_pkg::fail_res(jsu_pkg::ERR_EOF);
      s.ph = jsu_pkg::PH_IDLE;
    end else if (c == jsu_pkg::CH_QUOTE) begin
      s.l  = jsu_pkg::one_res(done);
      s.ph = jsu_pkg::PH_IDLE;
    end else if (c == jsu_pkg::CH_BSLASH) begin
      s.ph = jsu_pkg::PH_ESC;
    end else if (c < jsu_pkg::CH_SPACE) begin
      s.l  = jsu_pkg::fail_res(jsu_pkg::ERR_CONTROL);
      s.ph = jsu_pkg::PH_IDLE;
    end else begin
      s.l = jsu_pkg::one_res(jsu_pkg::data_res(c));
    end
    return s;
  endfunction

  // \u only moves to PH_HEX1 here; the caller clears the hex registers
  function automatic step_t do_escape(input logic [7:0] c);
    step_t s;
    s.l  = '0;
    s.ph = jsu_pkg::PH_PLAIN;
    case (c)
      jsu_pkg::CH_QUOTE:  s.l = jsu_pkg::one_res(jsu_pkg::data_res(jsu_pkg::CH_QUOTE));
      jsu_pkg::CH_BSLASH: s.l = jsu_pkg::one_res(jsu_pkg::data_res(jsu_pkg::CH_BSLASH));
      jsu_pkg::CH_SLASH:  s.l = jsu_pkg::one_res(jsu_pkg::data_res(jsu_pkg::CH_SLASH));
      jsu_pkg::CH_B:      s.l = jsu_pkg::one_res(jsu_pkg::data_res(jsu_pkg::CH_BS));
      jsu_pkg::CH_F:      s.l = jsu_pkg::one_res(jsu_pkg::data_res(jsu_pkg::CH_FF));
      jsu_pkg::CH_N:      s.l = jsu_pkg::one_res(jsu_pkg::data_res(jsu_pkg::CH_LF));
      jsu_pkg::CH_R:      s.l = jsu_pkg::one_res(jsu_pkg::data_res(jsu_pkg::CH_CR));
      jsu_pkg::CH_T:      s.l = jsu_pkg::one_res(jsu_pkg::data_res(jsu_pkg::CH_TAB));
      jsu_pkg::CH_U:      s.ph = jsu_pkg::PH_HEX1;
      jsu_pkg::CH_NUL: begin
        s.l  = jsu_pkg::fail_res(jsu_pkg::ERR_EOF);
        s.ph = jsu_pkg::PH_IDLE;
      end
      default: begin
        s.l  = jsu_pkg::fail_res(jsu_pkg::ERR_ESCAPE);
        s.ph = jsu_pkg::PH_IDLE;
      end
    endcase
    return s;
  endfunction

  logic [4:0]         hv;
  logic [15:0]        acc_shift;
  logic               bad_shift;
  logic               window_full;
  logic [20:0]        pair_cp;
  logic               pre;
  jsu_pkg::res_list_t main_l;
  step_t              s;

  assign hv          = jsu_pkg::hex_val(in_byte);
  assign acc_shift   = {st.hex_accum[11:0], hv[3:0]};
  assign bad_shift   = st.bad_digit_seen | ~hv[4];
  assign window_full = (st.digit_count == 2'd3);
  assign pair_cp     = {1'b0, st.held_high, acc_shift[9:0]} + 21'h10000;

  always_comb begin
    st_next = st;
    main_l  = '0;
    pre     = 1'b0;
    s       = '0;
    case (st.phase)
      jsu_pkg::PH_PLAIN: begin
        s             = do_plain(in_byte);
        main_l        = s.l;
        st_next.phase = s.ph;
      end
      jsu_pkg::PH_ESC, jsu_pkg::PH_HELD_ESC: begin
        if (st.phase == jsu_pkg::PH_HELD_ESC && in_byte == jsu_pkg::CH_U) begin
          st_next.phase = jsu_pkg::PH_HEX2;
        end else begin
          pre           = (st.phase == jsu_pkg::PH_HELD_ESC);
          s             = do_escape(in_byte);
          main_l        = s.l;
          st_next.phase = s.ph;
        end
        if (in_byte == jsu_pkg::CH_U) begin
          st_next.hex_accum      = 16'h0000;
          st_next.digit_count    = 2'd0;
          st_next.bad_digit_seen = 1'b0;
        end
      end
      jsu_pkg::PH_HELD: begin
        if (in_byte == jsu_pkg::CH_BSLASH) begin
          st_next.phase = jsu_pkg::PH_HELD_ESC;
        end else begin
          pre           = 1'b1;
          s             = do_plain(in_byte);
          main_l        = s.l;
          st_next.phase = s.ph;
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        if (in_byte == jsu_pkg::CH_NUL) begin
          main_l        = jsu_pkg::fail_res(jsu_pkg::ERR_EOF);
          st_next.phase = jsu_pkg::PH_IDLE;
        end else begin
          st_next.hex_accum      = acc_shift;
          st_next.bad_digit_seen = bad_shift;
          st_next.digit_count    = window_full ? 2'd0 : st.digit_count + 2'd1;
          if (window_full) begin
            pre = (st.phase == jsu_pkg::PH_HEX2);
            if (bad_shift) begin
              main_l        = jsu_pkg::fail_res(jsu_pkg::ERR_ESCAPE);
              st_next.phase = jsu_pkg::PH_IDLE;
            end else if (st.phase == jsu_pkg::PH_HEX2 &&
                         acc_shift >= 16'hDC00 && acc_shift <= 16'hDFFF) begin
              pre           = 1'b0;
              main_l        = jsu_pkg::encode(pair_cp);
              st_next.phase = jsu_pkg::PH_PLAIN;
            end else if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF) begin
              // high surrogate: hold until the next byte or escape decides
              st_next.held_high = acc_shift[9:0];
              st_next.phase     = jsu_pkg::PH_HELD;
            end else begin
              main_l        = jsu_pkg::encode({5'd0, acc_shift});
              st_next.phase = jsu_pkg::PH_PLAIN;
            end
          end
        end
      end
      jsu_pkg::PH_IDLE: begin
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          st_next = '0;
          st_next.phase = jsu_pkg::PH_PLAIN;
        end
      end
      default: begin
        st_next = '0;
        st_next.phase = jsu_pkg::PH_PLAIN;
      end
    endcase
  end

  // prepend '?' for a dropped high surrogate
  always_comb begin
    res.n = main_l.n + {2'b00, pre};
    if (pre) begin
      res.r[0] = jsu_pkg::data_res(jsu_pkg::CH_QMARK);
      for (int i = 1; i < jsu_pkg::MAX_RES; i++) begin
        res.r[i] = main_l.r[i-1];
      end
    end else begin
      res.r = main_l.r;
    end
  end

endmodule

FILE: hw/rtl/jsu_out_buf.sv
// Result register: holds the result bytes of one input byte and sends them one per transfer.
`timescale 1ns / 1ps

module jsu_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  jsu_pkg::res_list_t res,
  output logic               can_load,
  output logic               m_tvalid,
  input  logic               m_tready,
  output jsu_pkg::res_t      m_res,
  output logic               m_last
);

  jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0] buf_r;
  logic [2:0] count;
  logic [1:0] idx;
  logic       valid;

  assign m_tvalid = valid;
  assign m_res    = buf_r[idx];
  assign m_last   = ({1'b0, idx} == count - 3'd1);
  assign can_load = ~valid | (m_tready & m_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= (res.n != 3'd0);
      idx   <= 2'd0;
    end else if (valid && m_tready) begin
      if (m_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= res.r;
      count <= res.n;
    end
  end

endmodule
